### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthand used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/tdf_pkg.sv
// ---------------------------------------------------------------------------
// TFTP deframer package
// Packet kinds, result word layout and shared sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdf_pkg;

    localparam int DEF_MAX_CONTENT_BYTES = 512;
    localparam int QUEUE_DEPTH           = 4;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;
    localparam int INDEX_W  = 9;
    localparam int HALF_W   = 16;
    localparam int HDR_W    = 3;
    localparam int TDATA_W  = 64;
    localparam int TUSER_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        K_IDLE  = 4'd0,
        K_RRQ   = 4'd1,
        K_WRQ   = 4'd2,
        K_DATA  = 4'd3,
        K_ACK   = 4'd4,
        K_ERROR = 4'd5,
        K_DIRQ  = 4'd6,
        K_LOGRQ = 4'd7,
        K_DELRQ = 4'd8,
        K_BCAST = 4'd9,
        K_DISC  = 4'd10
    } t_kind;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               valid;
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic [HALF_W-1:0]  block;
        logic [HALF_W-1:0]  error;
        logic [BYTE_W-1:0]  flag;
        logic               ovf;
    } t_result;

endpackage

### rtl/core/tdf_front.sv
// ---------------------------------------------------------------------------
// TFTP deframer front end
// Parse one byte per cycle while i_accept is high and build any result word it causes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdf_front #(
    parameter int MAX_CONTENT_BYTES = tdf_pkg::DEF_MAX_CONTENT_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [tdf_pkg::BYTE_W-1:0]   i_byte,
    output logic                         o_push,
    output tdf_pkg::t_result             o_result
);

    localparam int CNT_W = $clog2(MAX_CONTENT_BYTES + 1);

    tdf_pkg::t_kind              r_kind, n_kind;
    logic [tdf_pkg::HDR_W-1:0]   r_hdr, n_hdr;
    logic [tdf_pkg::BYTE_W-1:0]  r_hi, n_hi;
    logic [tdf_pkg::HALF_W-1:0]  r_block, n_block;
    logic [tdf_pkg::HALF_W-1:0]  r_error, n_error;
    logic [tdf_pkg::HALF_W-1:0]  r_remain, n_remain;
    logic [tdf_pkg::BYTE_W-1:0]  r_flag, n_flag;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_ovf, n_ovf;

    logic                        w_clear;
    logic                        w_emit;
    logic                        w_valid;
    logic                        w_last;
    logic                        w_kept;
    logic [tdf_pkg::HALF_W-1:0]  w_pair;
    logic [tdf_pkg::HALF_W-1:0]  w_dec;
    logic [CNT_W+tdf_pkg::INDEX_W-1:0] w_cnt_ext;
    logic                        w_opcode_ok;

    assign w_pair      = {r_hi, i_byte};
    assign w_dec       = r_remain - 16'd1;
    assign w_kept      = (r_count < CNT_W'(MAX_CONTENT_BYTES));
    assign w_cnt_ext   = {{tdf_pkg::INDEX_W{1'b0}}, r_count};
    assign w_opcode_ok = (i_byte != 8'd0) && (i_byte <= 8'(tdf_pkg::K_DISC));

    // next packet kind
    always_comb begin
        n_kind = r_kind;
        if (w_clear) begin
            n_kind = tdf_pkg::K_IDLE;
        end else if (r_kind == tdf_pkg::K_IDLE && w_opcode_ok &&
                     i_byte != 8'(tdf_pkg::K_DIRQ) && i_byte != 8'(tdf_pkg::K_DISC)) begin
            n_kind = tdf_pkg::t_kind'(i_byte[tdf_pkg::KIND_W-1:0]);
        end
    end

    // header fields, content tracking and result
    always_comb begin
        n_hdr    = r_hdr;
        n_hi     = r_hi;
        n_block  = r_block;
        n_error  = r_error;
        n_remain = r_remain;
        n_flag   = r_flag;
        n_count  = r_count;
        n_ovf    = r_ovf;
        w_clear  = 1'b0;
        w_emit   = 1'b0;
        w_valid  = 1'b0;
        w_last   = 1'b0;
        case (r_kind)
            tdf_pkg::K_IDLE: begin
                if (w_opcode_ok) begin
                    if (i_byte == 8'(tdf_pkg::K_DIRQ) || i_byte == 8'(tdf_pkg::K_DISC)) begin
                        w_emit = 1'b1;
                        w_last = 1'b1;
                    end else begin
                        n_hdr = '0;
                    end
                end
            end
            tdf_pkg::K_DATA: begin
                if (r_hdr < 3'd4) begin
                    n_hdr = r_hdr + 3'd1;
                    if (!r_hdr[0]) begin
                        n_hi = i_byte;
                    end else if (r_hdr == 3'd1) begin
                        n_remain = w_pair;
                    end else begin
                        n_block = w_pair;
                        if (r_remain == '0) begin
                            w_emit  = 1'b1;
                            w_last  = 1'b1;
                            w_clear = 1'b1;
                        end
                    end
                end else begin
                    n_remain = w_dec;
                    if (w_kept) begin
                        w_emit  = 1'b1;
                        w_valid = 1'b1;
                        w_last  = (w_dec == '0);
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf  = 1'b1;
                        w_emit = (w_dec == '0);
                        w_last = (w_dec == '0);
                    end
                    w_clear = (w_dec == '0);
                end
            end
            tdf_pkg::K_ACK: begin
                if (r_hdr == '0) begin
                    n_hi  = i_byte;
                    n_hdr = 3'd1;
                end else begin
                    n_block = w_pair;
                    w_emit  = 1'b1;
                    w_last  = 1'b1;
                    w_clear = 1'b1;
                end
            end
            tdf_pkg::K_RRQ, tdf_pkg::K_WRQ, tdf_pkg::K_LOGRQ, tdf_pkg::K_DELRQ,
            tdf_pkg::K_ERROR, tdf_pkg::K_BCAST: begin
                if (r_kind == tdf_pkg::K_ERROR && r_hdr == 3'd0) begin
                    n_hi  = i_byte;
                    n_hdr = 3'd1;
                end else if (r_kind == tdf_pkg::K_ERROR && r_hdr == 3'd1) begin
                    n_error = w_pair;
                    n_hdr   = 3'd2;
                end else if (r_kind == tdf_pkg::K_BCAST && r_hdr == 3'd0) begin
                    n_flag = i_byte;
                    n_hdr  = 3'd1;
                end else if (i_byte == 8'd0) begin
                    w_emit  = 1'b1;
                    w_last  = 1'b1;
                    w_clear = 1'b1;
                end else if (w_kept) begin
                    w_emit  = 1'b1;
                    w_valid = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            default: begin
                w_clear = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_push          = i_accept && w_emit;
        o_result.kind   = (r_kind == tdf_pkg::K_IDLE) ? i_byte[tdf_pkg::KIND_W-1:0] : r_kind;
        o_result.valid  = w_valid;
        o_result.data   = w_valid ? i_byte : '0;
        o_result.index  = w_valid ? w_cnt_ext[tdf_pkg::INDEX_W-1:0] : '0;
        o_result.last   = w_last;
        o_result.block  = n_block;
        o_result.error  = n_error;
        o_result.flag   = n_flag;
        o_result.ovf    = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= tdf_pkg::K_IDLE;
            r_hdr    <= '0;
            r_hi     <= '0;
            r_block  <= '0;
            r_error  <= '0;
            r_remain <= '0;
            r_flag   <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else if (i_accept) begin
            r_kind <= n_kind;
            if (w_clear) begin
                r_hdr    <= '0;
                r_hi     <= '0;
                r_block  <= '0;
                r_error  <= '0;
                r_remain <= '0;
                r_flag   <= '0;
                r_count  <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_hdr    <= n_hdr;
                r_hi     <= n_hi;
                r_block  <= n_block;
                r_error  <= n_error;
                r_remain <= n_remain;
                r_flag   <= n_flag;
                r_count  <= n_count;
                r_ovf    <= n_ovf;
            end
        end
    end

endmodule

### rtl/core/tdf_queue.sv
// ---------------------------------------------------------------------------
// TFTP deframer result queue
// Short first-in first-out buffer between parser and output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tdf_pkg::t_result i_wdata,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output tdf_pkg::t_result o_rdata
);

    localparam int PTR_W = $clog2(tdf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tdf_pkg::QUEUE_DEPTH + 1);

    tdf_pkg::t_result r_mem [tdf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(tdf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = i_push ? r_wptr + PTR_W'(1) : r_wptr;
        n_rptr = i_pop  ? r_rptr + PTR_W'(1) : r_rptr;
        n_cnt  = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

### rtl/core/tdf_back.sv
// ---------------------------------------------------------------------------
// TFTP deframer output stage
// Register the head of the queue onto the master stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  tdf_pkg::t_result i_head,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output tdf_pkg::t_result o_result
);

    logic             r_valid, n_valid;
    tdf_pkg::t_result r_result;

    assign o_pop    = !i_empty && (!r_valid || i_ready);
    assign n_valid  = o_pop || (r_valid && !i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_head;
        end
    end

endmodule

### rtl/core/tftp_style_packet_deframer.sv
// ---------------------------------------------------------------------------
// TFTP-style packet deframer
// Path: an accepted byte's result word goes into a queue entry, then the
// output register, before the first edge that can accept it.
// Throughput: 1 byte per cycle while the queue is not full; the 4-entry queue decouples stalls.
// Reset: i_rst_n synchronous, active low; clears parser state and queue.
// After reset the block is idle and takes bytes on the next cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tftp_style_packet_deframer #(
    parameter int MAX_CONTENT_BYTES = tdf_pkg::DEF_MAX_CONTENT_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tdf_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] in_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] content_byte, [16:8] content_index, [32:17] block_number,
    // [48:33] error_value, [56:49] bcast_flag, [57] overflow, [63:58] zero
    output logic [tdf_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [tdf_pkg::TUSER_W-1:0]   m_axis_tuser,  // [3:0] packet_kind, [4] content_valid
    output logic                          m_axis_tlast   // packet_end
);

    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    tdf_pkg::t_result w_front_res;
    tdf_pkg::t_result w_head;
    tdf_pkg::t_result w_out;

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    tdf_front #(
        .MAX_CONTENT_BYTES (MAX_CONTENT_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .o_push   (w_push),
        .o_result (w_front_res)
    );

    tdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_front_res),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_rdata (w_head)
    );

    tdf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out)
    );

    assign m_axis_tdata = {6'b0, w_out.ovf, w_out.flag, w_out.error, w_out.block,
                           w_out.index, w_out.data};
    assign m_axis_tuser = {w_out.valid, w_out.kind};
    assign m_axis_tlast = w_out.last;

endmodule

### rtl/core/tdf_checker.sv
// ---------------------------------------------------------------------------
// TFTP deframer port checker
// Watch the top-level ports for output stream and result word consistency.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdf_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [tdf_pkg::BYTE_W-1:0]    s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [tdf_pkg::TDATA_W-1:0]   m_axis_tdata,
    input  logic [tdf_pkg::TUSER_W-1:0]   m_axis_tuser,
    input  logic                          m_axis_tlast
);

    logic w_in_seen;

    assign w_in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")
    `ASSERT_CLK(a_kind_range, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser[3:0] >= 4'(tdf_pkg::K_RRQ)) && (m_axis_tuser[3:0] <= 4'(tdf_pkg::K_DISC)), "packet kind out of range")
    `ASSERT_CLK(a_no_content_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[4] |-> (m_axis_tdata[16:0] == '0) && m_axis_tlast, "empty word carries content or no end")
    `ASSERT_CLK(a_header_kinds, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[4] |-> (m_axis_tuser[3:0] != 4'(tdf_pkg::K_ACK)) && (m_axis_tuser[3:0] != 4'(tdf_pkg::K_DIRQ)) && (m_axis_tuser[3:0] != 4'(tdf_pkg::K_DISC)), "content on a header-only packet")
    `ASSERT_CLK(a_quiet_after_reset, i_clk, i_rst_n, !$past(i_rst_n) |-> !m_axis_tvalid || $past(w_in_seen), "output word right after reset")

endmodule

bind tftp_style_packet_deframer tdf_checker u_tdf_checker (.*);
